@@ hw/rtl/mctt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_pkg
// Shared types and constants of the MIDI clock tempo tracker.
// ----------------------------------------------------------------------------
package mctt_pkg;

  localparam int TicksPerBeat = 24;
  localparam int FracBits     = 16;
  localparam int TimeWidth    = 32;
  localparam int CmdDepth     = 2;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] CFG_IDX_ENABLE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDX_SEED   = 2'd1;

  localparam logic [7:0] MIDI_CLOCK    = 8'hF8;
  localparam logic [7:0] MIDI_START    = 8'hFA;
  localparam logic [7:0] MIDI_CONTINUE = 8'hFB;
  localparam logic [7:0] MIDI_STOP     = 8'hFC;

  localparam logic [9:0] DEFAULT_BPM = 10'd120;

  typedef struct packed {
    logic beat;
    logic clk;
    logic start;
    logic stop;
  } flags_t;

  localparam int FlagsW = $bits(flags_t);

  typedef struct packed {
    logic [8:0]  displayed_bpm;
    logic [24:0] smoothed_bpm;
    flags_t      flags;
  } res_t;

endpackage

@@ hw/rtl/mctt_cmd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_cmd_fifo
// Short register queue between the classifier and the tempo engine.
// ----------------------------------------------------------------------------
module mctt_cmd_fifo #(
  parameter int WIDTH = 36,
  parameter int DEPTH = mctt_pkg::CmdDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ hw/rtl/mctt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_front
// Accepts status bytes, counts clock ticks and queues one command per item.
// ----------------------------------------------------------------------------
module mctt_front #(
  parameter int TICKS_PER_BEAT = mctt_pkg::TicksPerBeat,
  parameter int TIME_WIDTH     = mctt_pkg::TimeWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [7:0]            status_byte_i,
  input  logic [31:0]           time_us_i,
  input  logic                  clock_enable_i,
  input  logic                  q_full_i,
  output logic                  q_wr_o,
  output mctt_pkg::flags_t      q_flags_o,
  output logic [TIME_WIDTH-1:0] q_time_o
);

  localparam int TickW = (TICKS_PER_BEAT > 1) ? $clog2(TICKS_PER_BEAT) : 1;

  logic [TickW-1:0] tick_q;
  logic             accept;
  logic             is_clock;
  logic             last_tick;

  assign accept    = push_i && !q_full_i;
  assign is_clock  = clock_enable_i && (status_byte_i == mctt_pkg::MIDI_CLOCK);
  assign last_tick = (tick_q == TickW'(TICKS_PER_BEAT - 1));

  always_comb begin
    q_flags_o = '0;
    if (clock_enable_i) begin
      unique case (status_byte_i)
        mctt_pkg::MIDI_CLOCK: begin
          q_flags_o.clk  = 1'b1;
          q_flags_o.beat = last_tick;
        end
        mctt_pkg::MIDI_START, mctt_pkg::MIDI_CONTINUE: begin
          q_flags_o.clk   = 1'b1;
          q_flags_o.start = 1'b1;
        end
        mctt_pkg::MIDI_STOP: q_flags_o.stop = 1'b1;
        default: ;
      endcase
    end
  end

  assign q_wr_o   = accept;
  assign q_time_o = TIME_WIDTH'(time_us_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
    end else if (accept && is_clock) begin
      tick_q <= last_tick ? '0 : tick_q + 1'b1;
    end
  end

endmodule

@@ hw/rtl/mctt_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mctt_div #(
  parameter int DW  = 43,
  parameter int DVW = 22
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DW-1:0]  dividend_i,
  input  logic [DVW-1:0] divisor_i,
  output logic           done_o,
  output logic [DW-1:0]  quot_o
);

  localparam int CntW = $clog2(DW);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DVW:0]    rem_q;
  logic [DW-1:0]   quo_q;
  logic [DVW-1:0]  div_q;
  logic [DVW:0]    rem_sh;
  logic            fits;

  assign rem_sh = {rem_q[DVW-1:0], quo_q[DW-1]};
  assign fits   = (rem_sh >= {1'b0, div_q});
  assign done_o = done_q;
  assign quot_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sh - {1'b0, div_q} : rem_sh;
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/mctt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_back
// Tempo engine: beat period, estimate, adaptive smoothing, display hysteresis.
// ----------------------------------------------------------------------------
module mctt_back #(
  parameter int FRAC_BITS  = mctt_pkg::FracBits,
  parameter int TIME_WIDTH = mctt_pkg::TimeWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_empty_i,
  input  mctt_pkg::flags_t      cmd_flags_i,
  input  logic [TIME_WIDTH-1:0] cmd_time_i,
  output logic                  cmd_pop_o,
  input  logic [9:0]            seed_bpm_i,
  output mctt_pkg::res_t        res_o,
  output logic                  empty_o,
  input  logic                  pop_i
);

  localparam int SW  = 9 + FRAC_BITS;
  localparam int DW  = 27 + FRAC_BITS;
  localparam int DVW = (FRAC_BITS + 2 > 22) ? FRAC_BITS + 2 : 22;
  localparam int PW  = FRAC_BITS + 18;

  localparam logic [SW-1:0]  ONE_Q   = SW'(1) << FRAC_BITS;
  localparam logic [SW-1:0]  TWO_Q   = SW'(2) << FRAC_BITS;
  localparam logic [SW-1:0]  FIVE_Q  = SW'(5) << FRAC_BITS;
  localparam logic [SW-1:0]  HYST_Q  = SW'((65 * (2 ** FRAC_BITS) + 50) / 100);
  localparam logic [DW-1:0]  MIN_Q   = DW'(60000000) << FRAC_BITS;
  localparam logic [16:0]    COEF_BASE = 17'd9830;
  localparam logic [15:0]    COEF_SPAN = 16'd55706;
  localparam logic [18:0]    RECIP3    = 19'd349526;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_EST, ST_CLASS, ST_MUL_C, ST_DIV_C,
    ST_MUL_S, ST_APPLY, ST_HYST, ST_OUT
  } state_e;

  state_e                state_q;
  logic [TIME_WIDTH-1:0] last_q;
  logic                  first_q;
  logic [SW-1:0]         smooth_q, est_q, d_q;
  logic [8:0]            shown_q;
  logic                  up_q;
  logic [16:0]           c_q;
  logic [FRAC_BITS+2:0]  step_q;
  logic [PW-1:0]         prod_q;
  logic [36:0]           recip_q;
  mctt_pkg::flags_t      flags_q;
  logic                  out_valid_q;
  mctt_pkg::res_t        res_q;

  logic [TIME_WIDTH-1:0] period;
  logic                  in_range;
  logic                  take;
  logic [9:0]            seed;
  logic [SW-1:0]         est_n, dm2, shown_sh, dd;
  logic [FRAC_BITS+19:0] msum;
  logic [SW:0]           rnd;
  logic                  div_start, div_done;
  logic [DW-1:0]         div_a, quot;
  logic [DVW-1:0]        div_b;

  assign period   = cmd_time_i - last_q;
  assign in_range = (period > TIME_WIDTH'(120000)) && (period < TIME_WIDTH'(3000000));
  assign take     = (state_q == ST_IDLE) && !cmd_empty_i && !out_valid_q;
  assign cmd_pop_o = take;
  assign seed     = (seed_bpm_i < 10'd20 || seed_bpm_i > 10'd500) ?
                    mctt_pkg::DEFAULT_BPM : seed_bpm_i;
  assign est_n    = quot[SW-1:0];
  assign dm2      = d_q - TWO_Q;
  assign msum     = (FRAC_BITS+20)'(d_q[FRAC_BITS+2:0] * c_q) + (FRAC_BITS+20)'(32768);
  assign shown_sh = SW'(shown_q) << FRAC_BITS;
  assign dd       = (smooth_q > shown_sh) ? smooth_q - shown_sh : shown_sh - smooth_q;
  assign rnd      = (SW+1)'(smooth_q) + (SW+1)'(ONE_Q >> 1);

  assign div_start = take && cmd_flags_i.beat && !first_q && in_range;
  assign div_a     = MIN_Q + DW'(period[21:1]);
  assign div_b     = DVW'(period[21:0]);

  mctt_div #(.DW(DW), .DVW(DVW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign res_o   = res_q;
  assign empty_o = !out_valid_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      flags_q <= cmd_flags_i;
    end
    if (state_q == ST_DIV_EST && div_done) begin
      est_q <= est_n;
      up_q  <= est_n > smooth_q;
      d_q   <= (est_n > smooth_q) ? est_n - smooth_q : smooth_q - est_n;
    end
    if (state_q == ST_CLASS) begin
      prod_q <= dm2[FRAC_BITS+1:0] * COEF_SPAN;
    end
    // divide by 3 as a multiply by ceil(2^20 / 3), exact below 2^19
    if (state_q == ST_MUL_C) begin
      recip_q <= prod_q[PW-1:FRAC_BITS] * RECIP3;
    end
    if (state_q == ST_MUL_S) begin
      step_q <= msum[FRAC_BITS+18:16];
    end
    if (state_q == ST_OUT) begin
      res_q.displayed_bpm <= shown_q;
      res_q.smoothed_bpm  <= 25'(smooth_q);
      res_q.flags         <= flags_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= '0;
      first_q     <= 1'b1;
      smooth_q    <= SW'(120) << FRAC_BITS;
      shown_q     <= 9'd120;
      c_q         <= COEF_BASE;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (take) begin
            state_q <= ST_OUT;
            if (cmd_flags_i.beat) begin
              last_q <= cmd_time_i;
              if (first_q) begin
                first_q  <= 1'b0;
                smooth_q <= SW'(seed) << FRAC_BITS;
                shown_q  <= seed[8:0];
              end else if (in_range) begin
                state_q <= ST_DIV_EST;
              end
            end
          end
        end
        ST_DIV_EST: if (div_done) state_q <= ST_CLASS;
        ST_CLASS: begin
          priority if (d_q > FIVE_Q) begin
            smooth_q <= est_q;
            state_q  <= ST_HYST;
          end else if (d_q > TWO_Q) begin
            state_q <= ST_MUL_C;
          end else begin
            c_q     <= COEF_BASE;
            state_q <= ST_MUL_S;
          end
        end
        ST_MUL_C: state_q <= ST_DIV_C;
        ST_DIV_C: begin
          c_q     <= COEF_BASE + {1'b0, recip_q[35:20]};
          state_q <= ST_MUL_S;
        end
        ST_MUL_S: state_q <= ST_APPLY;
        ST_APPLY: begin
          smooth_q <= up_q ? smooth_q + SW'(step_q) : smooth_q - SW'(step_q);
          state_q  <= ST_HYST;
        end
        ST_HYST: begin
          if (dd > HYST_Q) begin
            shown_q <= rnd[FRAC_BITS+8:FRAC_BITS];
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // result slot is never overwritten while still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> !out_valid_q)
    else $error("result slot overwritten");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV_EST))
    else $error("divider finished with no owner");

  a_seed_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(first_q) |-> (smooth_q == (SW'(shown_q) << FRAC_BITS)))
    else $error("seed not applied to both tempos");

  a_cmd_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (state_q == ST_OUT || state_q == ST_DIV_EST))
    else $error("command taken outside idle");

endmodule

@@ hw/rtl/midi_clock_tempo_tracker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_clock_tempo_tracker_unit
// MIDI clock tempo tracker: beat period to smoothed and displayed BPM.
// ----------------------------------------------------------------------------
// Input queue side: drive status_byte_i and time_us_i with push_i; the item is
// taken when full_o is low. Every item gives exactly one result, in order, on
// the result side: it is on the ports while empty_o is low and leaves on pop_i.
// Configuration goes through cfg_valid_i / cfg_ready_o (always ready) with
// cfg_index_i 0 = clock enable, 1 = seed tempo; unknown indexes are dropped.
// The classifier takes an item a cycle, while full_o is low, into a two-entry
// command queue; the tempo engine handles one command at a time. A plain item
// (also a first or out-of-range beat) goes from idle straight to the output
// state, which registers the result. An in-range beat runs the estimate
// division, one quotient bit a cycle, then snaps, takes a small step, or in the
// ramp band first works out its coefficient; all then pass hysteresis and output.
// While the result is not popped the engine holds it and the command queue
// keeps filling; full_o rises once both entries wait. Reset clears the tick
// count, sets the first-beat flag and both tempos to 120 BPM.
// ----------------------------------------------------------------------------
module midi_clock_tempo_tracker_unit #(
  parameter int TICKS_PER_BEAT = mctt_pkg::TicksPerBeat,
  parameter int FRAC_BITS      = mctt_pkg::FracBits,
  parameter int TIME_WIDTH     = mctt_pkg::TimeWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [7:0]                    status_byte_i,
  input  logic [31:0]                   time_us_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [8:0]                    displayed_bpm_o,
  output logic [24:0]                   smoothed_bpm_o,
  output logic                          beat_update_o,
  output logic                          clock_seen_o,
  output logic                          start_seen_o,
  output logic                          stop_seen_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mctt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mctt_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int CmdW = TIME_WIDTH + mctt_pkg::FlagsW;

  logic                  clock_enable_q;
  logic [9:0]            seed_bpm_q;
  logic                  q_wr, q_full, q_empty, q_pop;
  mctt_pkg::flags_t      wr_flags, rd_flags;
  logic [TIME_WIDTH-1:0] wr_time, rd_time;
  logic [CmdW-1:0]       rd_data;
  mctt_pkg::res_t        res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_enable_q <= 1'b0;
      seed_bpm_q     <= mctt_pkg::DEFAULT_BPM;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mctt_pkg::CFG_IDX_ENABLE: clock_enable_q <= cfg_data_i[0];
        mctt_pkg::CFG_IDX_SEED:   seed_bpm_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mctt_front #(.TICKS_PER_BEAT(TICKS_PER_BEAT), .TIME_WIDTH(TIME_WIDTH)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .status_byte_i  (status_byte_i),
    .time_us_i      (time_us_i),
    .clock_enable_i (clock_enable_q),
    .q_full_i       (q_full),
    .q_wr_o         (q_wr),
    .q_flags_o      (wr_flags),
    .q_time_o       (wr_time)
  );

  assign full_o = q_full;

  mctt_cmd_fifo #(.WIDTH(CmdW), .DEPTH(mctt_pkg::CmdDepth)) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (q_wr),
    .wr_data_i ({wr_flags, wr_time}),
    .full_o    (q_full),
    .rd_en_i   (q_pop),
    .rd_data_o (rd_data),
    .empty_o   (q_empty)
  );

  assign rd_flags = rd_data[CmdW-1:TIME_WIDTH];
  assign rd_time  = rd_data[TIME_WIDTH-1:0];

  mctt_back #(.FRAC_BITS(FRAC_BITS), .TIME_WIDTH(TIME_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (q_empty),
    .cmd_flags_i (rd_flags),
    .cmd_time_i  (rd_time),
    .cmd_pop_o   (q_pop),
    .seed_bpm_i  (seed_bpm_q),
    .res_o       (res),
    .empty_o     (empty_o),
    .pop_i       (pop_i)
  );

  assign displayed_bpm_o = res.displayed_bpm;
  assign smoothed_bpm_o  = res.smoothed_bpm;
  assign beat_update_o   = res.flags.beat;
  assign clock_seen_o    = res.flags.clk;
  assign start_seen_o    = res.flags.start;
  assign stop_seen_o     = res.flags.stop;

endmodule

@@ tb/tb_midi_clock_tempo_tracker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_clock_tempo_tracker_unit
// Self-checking bench: MIDI bytes with arrival times go in through the push
// side. Each result popped is compared field by field with a typed row or a
// tempo tracker kept in the bench. The run covers directed extremes and beat
// edge cases, then randomised tempo phases with config changes and random idling.
// ----------------------------------------------------------------------------
module tb_midi_clock_tempo_tracker_unit;

  localparam int          NumItems   = 1550;
  localparam int          IdleLimit  = 3000;
  localparam logic [24:0] Q120       = 25'd7864320;
  localparam longint      OneQ       = 64'd65536;
  localparam longint      HystQ      = (65 * OneQ + 50) / 100;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          push_i = 1'b0;
  logic                          full_o;
  logic [7:0]                    status_byte_i = '0;
  logic [31:0]                   time_us_i = '0;
  logic                          empty_o;
  logic                          pop_i = 1'b0;
  logic [8:0]                    displayed_bpm_o;
  logic [24:0]                   smoothed_bpm_o;
  logic                          beat_update_o;
  logic                          clock_seen_o;
  logic                          start_seen_o;
  logic                          stop_seen_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [mctt_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [mctt_pkg::CfgDataW-1:0] cfg_data_i = '0;

  always #2 clk_i = ~clk_i;

  midi_clock_tempo_tracker_unit u_top (.*);

  // tempo tracker state held by the bench
  logic        enable_m;
  logic [9:0]  seed_m;
  int          ticks_m;
  logic [31:0] last_beat_m;
  bit          first_beat_m;
  longint      smooth_m;
  longint      shown_m;

  mctt_pkg::res_t tempo_q[$];
  int          errors = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          beats_seen = 0;
  int          phases = 0;
  int          idle_cycles = 0;
  int          pop_gap = 0;
  int          pop_hold = 0;
  bit          calm = 1'b0;

  function automatic mctt_pkg::res_t track_tempo(logic [7:0] sb, logic [31:0] t);
    mctt_pkg::res_t r;
    logic [31:0]    p32;
    longint         p, est, d, c, stp, dd;
    bit             up;
    r = '0;
    if (enable_m) begin
      if (sb == mctt_pkg::MIDI_CLOCK) begin
        r.flags.clk = 1'b1;
        ticks_m++;
        if (ticks_m >= mctt_pkg::TicksPerBeat) begin
          ticks_m = 0;
          r.flags.beat = 1'b1;
          p32 = t - last_beat_m;
          p = p32;
          last_beat_m = t;
          if (first_beat_m) begin
            first_beat_m = 1'b0;
            shown_m = (seed_m < 20 || seed_m > 500) ? 120 : seed_m;
            smooth_m = shown_m * OneQ;
          end else if (p > 120000 && p < 3000000) begin
            est = ((64'd60000000 * OneQ) + (p >> 1)) / p;
            up = est > smooth_m;
            d = up ? est - smooth_m : smooth_m - est;
            if (d > 5 * OneQ) begin
              smooth_m = est;
            end else begin
              c = 9830;
              if (d > 2 * OneQ) c += ((d - 2 * OneQ) * 55706) / (3 * OneQ);
              stp = (d * c + 32768) >> 16;
              smooth_m = up ? smooth_m + stp : smooth_m - stp;
            end
            dd = smooth_m > shown_m * OneQ ? smooth_m - shown_m * OneQ
                                           : shown_m * OneQ - smooth_m;
            if (dd > HystQ) shown_m = ((smooth_m + OneQ / 2) >> 16) & 9'h1FF;
          end
        end
      end else if (sb == mctt_pkg::MIDI_START || sb == mctt_pkg::MIDI_CONTINUE) begin
        r.flags.clk = 1'b1;
        r.flags.start = 1'b1;
      end else if (sb == mctt_pkg::MIDI_STOP) begin
        r.flags.stop = 1'b1;
      end
    end
    r.displayed_bpm = shown_m[8:0];
    r.smoothed_bpm = smooth_m[24:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic [7:0] sb, logic [31:0] t, bit typed,
                           mctt_pkg::res_t want);
    int             gap;
    mctt_pkg::res_t got;
    gap = pick_gap();
    if (gap > 0) begin
      push_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    status_byte_i = sb;
    time_us_i = t;
    push_i = 1'b1;
    do @(posedge clk_i); while (full_o);
    got = track_tempo(sb, t);
    tempo_q.push_back(typed ? want : got);
    items_sent++;
    @(negedge clk_i);
    push_i = 1'b0;
  endtask

  task automatic write_reg(logic [mctt_pkg::CfgIdxW-1:0] idx,
                           logic [mctt_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == mctt_pkg::CFG_IDX_ENABLE) enable_m = data[0];
    else if (idx == mctt_pkg::CFG_IDX_SEED) seed_m = data;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain_results();
    while (tempo_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  typedef struct {
    logic [7:0]     sb;
    int unsigned    reps;
    int unsigned    dt;
    bit             typed;
    mctt_pkg::res_t want;
  } stim_row_t;

  localparam mctt_pkg::res_t ResIdle  = '{9'd120, Q120, '{1'b0, 1'b0, 1'b0, 1'b0}};
  localparam mctt_pkg::res_t ResStart = '{9'd120, Q120, '{1'b0, 1'b1, 1'b1, 1'b0}};
  localparam mctt_pkg::res_t ResStop  = '{9'd120, Q120, '{1'b0, 1'b0, 1'b0, 1'b1}};

  // clock disabled straight after reset: everything is ignored
  stim_row_t rows_off[5] = '{
    '{mctt_pkg::MIDI_CLOCK,    1, 7,   1'b1, ResIdle},
    '{mctt_pkg::MIDI_START,    1, 7,   1'b1, ResIdle},
    '{mctt_pkg::MIDI_STOP,     1, 7,   1'b1, ResIdle},
    '{8'hFF,                   1, 7,   1'b1, ResIdle},
    '{8'h00,                   1, 7,   1'b1, ResIdle}
  };

  // clock enabled, out-of-range seed, time starts just below the wrap
  stim_row_t rows_on[13] = '{
    '{mctt_pkg::MIDI_START,    1,  100,    1'b1, ResStart},
    '{mctt_pkg::MIDI_CONTINUE, 1,  100,    1'b1, ResStart},
    '{mctt_pkg::MIDI_STOP,     1,  100,    1'b1, ResStop},
    '{8'h00,                   1,  100,    1'b1, ResIdle},
    '{mctt_pkg::MIDI_CLOCK,    24, 20833,  1'b0, ResIdle},  // first beat, seed falls back
    '{mctt_pkg::MIDI_CLOCK,    24, 20833,  1'b0, ResIdle},
    '{mctt_pkg::MIDI_CLOCK,    24, 5000,   1'b0, ResIdle},  // period on the lower bound
    '{mctt_pkg::MIDI_CLOCK,    24, 5001,   1'b0, ResIdle},  // just inside, snap to ~500
    '{mctt_pkg::MIDI_CLOCK,    24, 125000, 1'b0, ResIdle},  // period on the upper bound
    '{mctt_pkg::MIDI_CLOCK,    24, 124999, 1'b0, ResIdle},  // just inside, 20 bpm
    '{mctt_pkg::MIDI_CLOCK,    24, 104166, 1'b0, ResIdle},  // ramp band
    '{mctt_pkg::MIDI_CLOCK,    24, 100000, 1'b0, ResIdle},  // ramp band again
    '{mctt_pkg::MIDI_STOP,     1,  100,    1'b0, ResIdle}
  };

  // receiver: random pop idling plus one long hold-off
  always @(negedge clk_i) begin
    if (pop_hold > 0) begin
      pop_i <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if (pop_gap > 0) begin
      pop_i <= 1'b0;
      pop_gap <= pop_gap - 1;
    end else begin
      pop_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    mctt_pkg::res_t want;
    if (rst_ni && pop_i && !empty_o) begin
      results_seen++;
      if (beat_update_o) beats_seen++;
      if (results_seen == 250) pop_hold = 400;
      pop_gap = pick_gap();
      if (tempo_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item at %0t", $realtime);
      end else begin
        want = tempo_q.pop_front();
        if (want.displayed_bpm !== displayed_bpm_o || want.smoothed_bpm !== smoothed_bpm_o ||
            want.flags.beat !== beat_update_o || want.flags.clk !== clock_seen_o ||
            want.flags.start !== start_seen_o || want.flags.stop !== stop_seen_o) begin
          errors++;
          if (errors <= 10) begin
            $write("mismatch item %0d: exp bpm=%0d q=%h b/c/s/p=%b%b%b%b ",
                   results_seen, want.displayed_bpm, want.smoothed_bpm, want.flags.beat,
                   want.flags.clk, want.flags.start, want.flags.stop);
            $display("got bpm=%0d q=%h b/c/s/p=%b%b%b%b", displayed_bpm_o,
                     smoothed_bpm_o, beat_update_o, clock_seen_o, start_seen_o,
                     stop_seen_o);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o) || (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [31:0] now;
    int          dt, jit, n, kind;
    logic [9:0]  seed;
    enable_m = 1'b0;
    seed_m = mctt_pkg::DEFAULT_BPM;
    ticks_m = 0;
    last_beat_m = '0;
    first_beat_m = 1'b1;
    smooth_m = 120 * OneQ;
    shown_m = 120;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    now = 32'h1234_5678;
    foreach (rows_off[i]) begin
      now += rows_off[i].dt;
      send_item(rows_off[i].sb, now, rows_off[i].typed, rows_off[i].want);
    end
    drain_results();
    write_reg(mctt_pkg::CFG_IDX_ENABLE, 10'd1);
    write_reg(mctt_pkg::CFG_IDX_SEED, 10'd1023);
    write_reg(2'd3, 10'h3FF);  // unknown index, dropped
    now = 32'hFFF0_0000;
    foreach (rows_on[i]) begin
      for (int k = 0; k < rows_on[i].reps; k++) begin
        now += rows_on[i].dt;
        send_item(rows_on[i].sb, now, rows_on[i].typed, rows_on[i].want);
      end
    end

    while (items_sent < NumItems) begin
      drain_results();
      phases++;
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 6))
        0: seed = 10'd0;
        1: seed = 10'd19;
        2: seed = 10'd20;
        3: seed = 10'd500;
        4: seed = 10'd1023;
        default: seed = 10'($urandom_range(0, 1023));
      endcase
      write_reg(mctt_pkg::CFG_IDX_SEED, seed);
      write_reg(mctt_pkg::CFG_IDX_ENABLE, {9'd0, $urandom_range(0, 7) != 0});
      if ($urandom_range(0, 3) == 0) write_reg(2'd2, 10'($urandom_range(0, 1023)));
      now = $urandom;
      dt = $urandom_range(4000, 130000);
      jit = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, dt / 50);
      n = $urandom_range(80, 220);
      if (n > NumItems - items_sent) n = NumItems - items_sent;
      for (int k = 0; k < n; k++) begin
        kind = $urandom_range(0, 99);
        // slow drift keeps the smoother in its ramp and small-step bands
        if (k % 24 == 0 && $urandom_range(0, 2) == 0)
          dt = dt + $urandom_range(0, dt / 20) - dt / 40 + 1;
        now += 32'(dt + $urandom_range(0, jit) - jit / 2);
        if (kind < 88) begin
          send_item(mctt_pkg::MIDI_CLOCK, now, 1'b0, ResIdle);
        end else if (kind < 91) begin
          send_item(kind[0] ? mctt_pkg::MIDI_START : mctt_pkg::MIDI_CONTINUE, now, 1'b0,
                    ResIdle);
        end else if (kind < 94) begin
          send_item(mctt_pkg::MIDI_STOP, now, 1'b0, ResIdle);
        end else begin
          send_item(8'($urandom_range(0, 255)), now, 1'b0, ResIdle);
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    $display("covered %0d items, %0d results, %0d beats over %0d random tempo phases",
             items_sent, results_seen, beats_seen, phases);
    if (errors == 0 && tempo_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("mismatches: %0d, items still expected: %0d", errors, tempo_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/mctt_pkg.sv
hw/rtl/mctt_cmd_fifo.sv
hw/rtl/mctt_front.sv
hw/rtl/mctt_div.sv
hw/rtl/mctt_back.sv
hw/rtl/midi_clock_tempo_tracker_unit.sv
tb/tb_midi_clock_tempo_tracker_unit.sv
